### rtl/erpp_pkg.sv
// Shared constants, widths and tables for the Euler rotation and point projection block.
// No dependencies; every rtl file refers to it by scoped names.
package erpp_pkg;

  localparam int COORD_W      = 16;
  localparam int ANG_W        = 16;
  localparam int Q14_W        = 16;
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > 16) ? 16 : CORDIC_STEPS;
  localparam int ITER_W       = $clog2(CORDIC_ITERS + 1);
  localparam int CORDIC_W     = 20;
  localparam int OPA_W        = 18;
  localparam int OPB_W        = (COORD_W > 18) ? COORD_W : 18;
  localparam int ACC_W        = OPA_W + OPB_W + 3;
  localparam int RND_W        = ACC_W - 14;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_H = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_V = 1'd1;

  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(39797);
  localparam logic signed [Q14_W-1:0] ONE_Q14 = 16'sd16384;

  function automatic logic signed [CORDIC_W-1:0] atan_q16(input logic [3:0] idx);
    logic signed [CORDIC_W-1:0] v;
    unique case (idx)
      4'd0:  v = CORDIC_W'(51472);
      4'd1:  v = CORDIC_W'(30385);
      4'd2:  v = CORDIC_W'(16055);
      4'd3:  v = CORDIC_W'(8150);
      4'd4:  v = CORDIC_W'(4091);
      4'd5:  v = CORDIC_W'(2047);
      4'd6:  v = CORDIC_W'(1024);
      4'd7:  v = CORDIC_W'(512);
      4'd8:  v = CORDIC_W'(256);
      4'd9:  v = CORDIC_W'(128);
      4'd10: v = CORDIC_W'(64);
      4'd11: v = CORDIC_W'(32);
      4'd12: v = CORDIC_W'(16);
      4'd13: v = CORDIC_W'(8);
      4'd14: v = CORDIC_W'(4);
      default: v = CORDIC_W'(2);
    endcase
    return v;
  endfunction

endpackage

### rtl/erpp_cordic.sv
// Iterative CORDIC sine/cosine unit: one micro-rotation per cycle, Q3.12 in, Q1.14 out.
// Depends on erpp_pkg.
module erpp_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [erpp_pkg::ANG_W-1:0]  angle,
  output logic                               done,
  output logic signed [erpp_pkg::Q14_W-1:0]  sin_q14,
  output logic signed [erpp_pkg::Q14_W-1:0]  cos_q14
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cst_t;

  cst_t state_r;
  logic [erpp_pkg::ITER_W-1:0] iter_r;
  logic signed [erpp_pkg::CORDIC_W-1:0] x_r, y_r, z_r;
  logic flip_r;
  logic done_r;
  logic signed [erpp_pkg::Q14_W-1:0] sin_r, cos_r;

  logic signed [16:0] a_ext, a_wrap, a_fold;
  logic fold_flip;
  logic signed [erpp_pkg::CORDIC_W-1:0] sh_x, sh_y, x_nxt, y_nxt, z_nxt, ang_c;
  logic signed [erpp_pkg::CORDIC_W-1:0] x_rnd, y_rnd, x_fin, y_fin;

  always_comb begin
    a_ext = 17'(angle);
    if (a_ext > erpp_pkg::PI_Q12) begin
      a_wrap = a_ext - 17'(erpp_pkg::TWO_PI_Q12);
    end else if (a_ext < -erpp_pkg::PI_Q12) begin
      a_wrap = a_ext + 17'(erpp_pkg::TWO_PI_Q12);
    end else begin
      a_wrap = a_ext;
    end
    fold_flip = 1'b0;
    if (a_wrap > erpp_pkg::HALF_PI_Q12) begin
      a_fold = a_wrap - erpp_pkg::PI_Q12;
      fold_flip = 1'b1;
    end else if (a_wrap < -erpp_pkg::HALF_PI_Q12) begin
      a_fold = a_wrap + erpp_pkg::PI_Q12;
      fold_flip = 1'b1;
    end else begin
      a_fold = a_wrap;
    end
  end

  always_comb begin
    sh_x = x_r >>> iter_r[3:0];
    sh_y = y_r >>> iter_r[3:0];
    ang_c = erpp_pkg::atan_q16(iter_r[3:0]);
    if (!z_r[erpp_pkg::CORDIC_W-1]) begin
      x_nxt = x_r - sh_y;
      y_nxt = y_r + sh_x;
      z_nxt = z_r - ang_c;
    end else begin
      x_nxt = x_r + sh_y;
      y_nxt = y_r - sh_x;
      z_nxt = z_r + ang_c;
    end
    x_rnd = (x_r + $signed(erpp_pkg::CORDIC_W'(2))) >>> 2;
    y_rnd = (y_r + $signed(erpp_pkg::CORDIC_W'(2))) >>> 2;
    x_fin = flip_r ? -x_rnd : x_rnd;
    y_fin = flip_r ? -y_rnd : y_rnd;
  end

  function automatic logic signed [erpp_pkg::Q14_W-1:0] sat_q14(
    input logic signed [erpp_pkg::CORDIC_W-1:0] v);
    logic signed [erpp_pkg::Q14_W-1:0] r;
    if (v > $signed(erpp_pkg::CORDIC_W'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -$signed(erpp_pkg::CORDIC_W'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[erpp_pkg::Q14_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            x_r     <= erpp_pkg::CORDIC_GAIN;
            y_r     <= '0;
            z_r     <= erpp_pkg::CORDIC_W'(a_fold) <<< 4;
            flip_r  <= fold_flip;
            iter_r  <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          x_r    <= x_nxt;
          y_r    <= y_nxt;
          z_r    <= z_nxt;
          iter_r <= iter_r + 1'b1;
          if (iter_r == erpp_pkg::ITER_W'(erpp_pkg::CORDIC_ITERS - 1)) begin
            state_r <= C_FIN;
          end
        end
        C_FIN: begin
          cos_r   <= sat_q14(x_fin);
          sin_r   <= sat_q14(y_fin);
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign sin_q14 = sin_r;
  assign cos_q14 = cos_r;

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_FIN) |=> done_r)
    else $error("cordic done missing after final step");
  a_done_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == C_FIN))
    else $error("cordic done without final step");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_RUN) |-> (iter_r < erpp_pkg::ITER_W'(erpp_pkg::CORDIC_ITERS)))
    else $error("cordic iteration count overrun");

endmodule

### rtl/euler_rotate_project_points_top.sv
// A rotate item steps the angle sums, runs the CORDIC unit per angle and rebuilds the rows,
// with no result; a point item gives one result. One item at a time: set by the serial
// CORDIC unit and the single shared 18x18 multiply-accumulate, stepped by a microcode counter.
// Synchronous active-low reset: angle sums zero, rows of the zero-angle rotation, offsets zero, output empty.
// Depends on erpp_pkg and erpp_cordic.
module euler_rotate_project_points_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic signed [erpp_pkg::ANG_W-1:0]     in_step_x,
  input  logic signed [erpp_pkg::ANG_W-1:0]     in_step_y,
  input  logic signed [erpp_pkg::ANG_W-1:0]     in_step_z,
  input  logic signed [erpp_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [erpp_pkg::COORD_W-1:0]   in_point_y,
  input  logic signed [erpp_pkg::COORD_W-1:0]   in_point_z,
  input  logic                                  in_last_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [erpp_pkg::COORD_W-1:0]   out_screen_h,
  output logic signed [erpp_pkg::COORD_W-1:0]   out_screen_v,
  output logic                                  out_last_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [erpp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic signed [erpp_pkg::COORD_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_ANGLE, S_CORDIC, S_MAC} state_t;
  typedef enum logic [3:0] {
    WB_NONE, WB_A2, WB_A3, WB_R0, WB_R1, WB_R2, WB_R3, WB_R4, WB_R5, WB_NY, WB_NZ
  } wb_t;

  localparam logic [4:0] STEP_LAST_ROT = 5'd19;
  localparam logic [4:0] STEP_PT       = 5'd20;
  localparam logic [4:0] STEP_LAST_PT  = 5'd27;

  state_t state_r;
  logic [4:0] step_r;
  logic [1:0] ang_idx_r;
  logic cord_start_r;
  logic signed [erpp_pkg::ANG_W-1:0] sum_r [3];
  logic signed [erpp_pkg::Q14_W-1:0] sin_r [3];
  logic signed [erpp_pkg::Q14_W-1:0] cos_r [3];
  logic signed [erpp_pkg::Q14_W-1:0] rows_r [6];
  logic signed [erpp_pkg::OPA_W-1:0] a2_r, a3_r;
  logic signed [erpp_pkg::ACC_W-1:0] acc_r;
  logic signed [erpp_pkg::COORD_W-1:0] px_r, py_r, pz_r, off_h_r, off_v_r, h_r, v_r, ny_r;
  logic last_r, out_last_r, out_valid_r;

  logic cord_done;
  logic signed [erpp_pkg::Q14_W-1:0] cord_sin, cord_cos;
  logic signed [erpp_pkg::ANG_W-1:0] steps [3];
  logic signed [17:0] ang_sum [3];
  logic signed [17:0] ang_wrap [3];
  logic signed [erpp_pkg::ANG_W-1:0] ang_sat [3];

  logic is_mul, op_clr, op_neg;
  wb_t op_wb;
  logic signed [erpp_pkg::OPA_W-1:0] op_a;
  logic signed [erpp_pkg::OPB_W-1:0] op_b;
  logic signed [erpp_pkg::OPA_W+erpp_pkg::OPB_W-1:0] prod;
  logic signed [erpp_pkg::ACC_W-1:0] acc_base, acc_nxt, acc_rnd;
  logic signed [erpp_pkg::RND_W:0] rnd, rnd_neg, sum_h, sum_v;
  logic out_hold;

  erpp_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cord_start_r),
    .angle   (sum_r[ang_idx_r]),
    .done    (cord_done),
    .sin_q14 (cord_sin),
    .cos_q14 (cord_cos)
  );

  assign steps[0] = in_step_x;
  assign steps[1] = in_step_y;
  assign steps[2] = in_step_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ang_sum[i] = 18'(sum_r[i]) + 18'(steps[i]);
      if (ang_sum[i] > erpp_pkg::TWO_PI_Q12) begin
        ang_wrap[i] = ang_sum[i] - erpp_pkg::TWO_PI_Q12;
      end else if (ang_sum[i] < -erpp_pkg::TWO_PI_Q12) begin
        ang_wrap[i] = ang_sum[i] + erpp_pkg::TWO_PI_Q12;
      end else begin
        ang_wrap[i] = ang_sum[i];
      end
      if (ang_wrap[i] > 18'sd32767) begin
        ang_sat[i] = 16'sh7fff;
      end else if (ang_wrap[i] < -18'sd32768) begin
        ang_sat[i] = 16'sh8000;
      end else begin
        ang_sat[i] = ang_wrap[i][erpp_pkg::ANG_W-1:0];
      end
    end
  end

  always_comb begin
    is_mul = 1'b1;
    op_clr = 1'b0;
    op_neg = 1'b0;
    op_wb  = WB_NONE;
    op_a   = '0;
    op_b   = '0;
    unique case (step_r)
      5'd0:  begin op_clr = 1'b1; op_a = 18'(sin_r[0]); op_b = erpp_pkg::OPB_W'(sin_r[1]); end
      5'd1:  begin is_mul = 1'b0; op_wb = WB_A2; end
      5'd2:  begin op_clr = 1'b1; op_a = 18'(cos_r[0]); op_b = erpp_pkg::OPB_W'(sin_r[1]); end
      5'd3:  begin is_mul = 1'b0; op_wb = WB_A3; end
      5'd4:  begin op_clr = 1'b1; op_a = 18'(sin_r[0]); op_b = erpp_pkg::OPB_W'(cos_r[1]); end
      5'd5:  begin is_mul = 1'b0; op_wb = WB_R2; end
      5'd6:  begin op_clr = 1'b1; op_a = 18'(cos_r[0]); op_b = erpp_pkg::OPB_W'(cos_r[1]); end
      5'd7:  begin is_mul = 1'b0; op_wb = WB_R5; end
      5'd8:  begin op_clr = 1'b1; op_a = a2_r; op_b = erpp_pkg::OPB_W'(cos_r[2]); end
      5'd9:  begin op_a = 18'(cos_r[0]); op_b = erpp_pkg::OPB_W'(sin_r[2]); end
      5'd10: begin is_mul = 1'b0; op_wb = WB_R0; end
      5'd11: begin
        op_clr = 1'b1; op_neg = 1'b1; op_a = a2_r; op_b = erpp_pkg::OPB_W'(sin_r[2]);
      end
      5'd12: begin op_a = 18'(cos_r[0]); op_b = erpp_pkg::OPB_W'(cos_r[2]); end
      5'd13: begin is_mul = 1'b0; op_wb = WB_R1; end
      5'd14: begin op_clr = 1'b1; op_a = a3_r; op_b = erpp_pkg::OPB_W'(cos_r[2]); end
      5'd15: begin op_a = 18'(sin_r[0]); op_b = erpp_pkg::OPB_W'(sin_r[2]); end
      5'd16: begin is_mul = 1'b0; op_wb = WB_R3; end
      5'd17: begin
        op_clr = 1'b1; op_neg = 1'b1; op_a = a3_r; op_b = erpp_pkg::OPB_W'(sin_r[2]);
      end
      5'd18: begin op_a = 18'(sin_r[0]); op_b = erpp_pkg::OPB_W'(cos_r[2]); end
      5'd19: begin is_mul = 1'b0; op_wb = WB_R4; end
      5'd20: begin op_clr = 1'b1; op_a = 18'(rows_r[0]); op_b = erpp_pkg::OPB_W'(px_r); end
      5'd21: begin op_a = 18'(rows_r[1]); op_b = erpp_pkg::OPB_W'(py_r); end
      5'd22: begin op_a = 18'(rows_r[2]); op_b = erpp_pkg::OPB_W'(pz_r); end
      5'd23: begin is_mul = 1'b0; op_wb = WB_NY; end
      5'd24: begin op_clr = 1'b1; op_a = 18'(rows_r[3]); op_b = erpp_pkg::OPB_W'(px_r); end
      5'd25: begin op_a = 18'(rows_r[4]); op_b = erpp_pkg::OPB_W'(py_r); end
      5'd26: begin op_a = 18'(rows_r[5]); op_b = erpp_pkg::OPB_W'(pz_r); end
      5'd27: begin is_mul = 1'b0; op_wb = WB_NZ; end
      default: begin is_mul = 1'b0; end
    endcase
  end

  always_comb begin
    prod     = op_a * op_b;
    acc_base = op_clr ? '0 : acc_r;
    acc_nxt  = op_neg ? acc_base - erpp_pkg::ACC_W'(prod)
                      : acc_base + erpp_pkg::ACC_W'(prod);
    acc_rnd  = (acc_r + $signed(erpp_pkg::ACC_W'(8192))) >>> 14;
    rnd      = acc_rnd[erpp_pkg::RND_W:0];
    rnd_neg  = -rnd;
    sum_h    = rnd + (erpp_pkg::RND_W + 1)'(off_h_r);
    sum_v    = rnd + (erpp_pkg::RND_W + 1)'(off_v_r);
    out_hold = out_valid_r && out_stall;
  end

  function automatic logic signed [erpp_pkg::Q14_W-1:0] sat_q14(
    input logic signed [erpp_pkg::RND_W:0] v);
    logic signed [erpp_pkg::Q14_W-1:0] r;
    if (v > $signed((erpp_pkg::RND_W + 1)'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -$signed((erpp_pkg::RND_W + 1)'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[erpp_pkg::Q14_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [erpp_pkg::COORD_W-1:0] sat_coord(
    input logic signed [erpp_pkg::RND_W:0] v);
    logic signed [erpp_pkg::RND_W:0] hi, lo;
    logic signed [erpp_pkg::COORD_W-1:0] r;
    hi = (erpp_pkg::RND_W + 1)'((64'sd1 <<< (erpp_pkg::COORD_W - 1)) - 64'sd1);
    lo = -hi - (erpp_pkg::RND_W + 1)'(1);
    if (v > hi) begin
      r = hi[erpp_pkg::COORD_W-1:0];
    end else if (v < lo) begin
      r = lo[erpp_pkg::COORD_W-1:0];
    end else begin
      r = v[erpp_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      ang_idx_r    <= '0;
      cord_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      off_h_r      <= '0;
      off_v_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
      for (int i = 0; i < 6; i++) begin
        rows_r[i] <= '0;
      end
      rows_r[1] <= erpp_pkg::ONE_Q14;
      rows_r[5] <= erpp_pkg::ONE_Q14;
    end else begin
      cord_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          erpp_pkg::REG_OFFSET_H: off_h_r <= cfg_data;
          erpp_pkg::REG_OFFSET_V: off_v_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_cmd) begin
              px_r    <= in_point_x;
              py_r    <= in_point_y;
              pz_r    <= in_point_z;
              last_r  <= in_last_in;
              step_r  <= STEP_PT;
              state_r <= S_MAC;
            end else begin
              for (int i = 0; i < 3; i++) begin
                sum_r[i] <= ang_sat[i];
              end
              state_r <= S_ANGLE;
            end
          end
        end
        S_ANGLE: begin
          ang_idx_r    <= '0;
          cord_start_r <= 1'b1;
          state_r      <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cord_done) begin
            sin_r[ang_idx_r] <= cord_sin;
            cos_r[ang_idx_r] <= cord_cos;
            if (ang_idx_r == 2'd2) begin
              step_r  <= '0;
              state_r <= S_MAC;
            end else begin
              ang_idx_r    <= ang_idx_r + 2'd1;
              cord_start_r <= 1'b1;
            end
          end
        end
        S_MAC: begin
          if (is_mul) begin
            acc_r <= acc_nxt;
          end
          unique case (op_wb)
            WB_A2: a2_r <= rnd[erpp_pkg::OPA_W-1:0];
            WB_A3: a3_r <= rnd_neg[erpp_pkg::OPA_W-1:0];
            WB_R0: rows_r[0] <= sat_q14(rnd);
            WB_R1: rows_r[1] <= sat_q14(rnd);
            WB_R2: rows_r[2] <= sat_q14(rnd_neg);
            WB_R3: rows_r[3] <= sat_q14(rnd);
            WB_R4: rows_r[4] <= sat_q14(rnd);
            WB_R5: rows_r[5] <= sat_q14(rnd);
            WB_NY: ny_r <= sat_coord(sum_v);
            WB_NZ: begin
              if (!out_hold) begin
                h_r         <= sat_coord(sum_h);
                v_r         <= ny_r;
                out_last_r  <= last_r;
                out_valid_r <= 1'b1;
              end
            end
            default: ;
          endcase
          priority if (step_r == STEP_LAST_PT) begin
            if (!out_hold) begin
              state_r <= S_IDLE;
            end
          end else if (step_r == STEP_LAST_ROT) begin
            state_r <= S_IDLE;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_screen_h = h_r;
  assign out_screen_v = v_r;
  assign out_last_out = out_last_r;

  a_rot_enters_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_cmd) |=> (state_r == S_ANGLE))
    else $error("rotate transfer did not start angle update");
  a_pt_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && step_r == STEP_LAST_PT && !out_hold) |=> out_valid_r)
    else $error("point finished without result");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (step_r <= STEP_LAST_PT))
    else $error("microcode step out of range");
  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == S_CORDIC))
    else $error("cordic result outside rebuild");

endmodule
